[hdl/rgb_to_lab_pixel_converter_macros.svh]
// Assertion macros used by the checker module of the RGB to Lab converter.
`ifndef RGB_TO_LAB_PIXEL_CONVERTER_MACROS_SVH
`define RGB_TO_LAB_PIXEL_CONVERTER_MACROS_SVH

// Same-cycle implication, sampled on clk and muted during reset.
`define R2L_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and muted during reset.
`define R2L_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/r2l_pkg.sv]
// Constants and elaboration-time table builders for the RGB to Lab converter.
`default_nettype none

package r2l_pkg;

	// RGB to XYZ matrix coefficients in millionths, row by row.
	localparam int unsigned MAT_MICRO [9] = '{
		412453, 357580, 180423,
		212671, 715160, 72169,
		19334, 119193, 950227
	};

	// White point as a ratio: 95.047, 100 and 108.883 for X, Y and Z.
	localparam int unsigned WP_NUM [3] = '{1000, 1, 1000};
	localparam int unsigned WP_DEN [3] = '{95047, 100, 108883};

	// Offsets added to L, a and b after truncation.
	localparam logic [7:0] OFFSET_L  = 8'd0;
	localparam logic [7:0] OFFSET_AB = 8'd128;

	// Coefficient rounded to frac fractional bits.
	function automatic logic [63:0] coef_fx(input int unsigned micro, input int unsigned frac);
		logic [63:0] scaled;
		scaled = (64'(micro) << frac) + 64'd500000;
		return scaled / 64'd1000000;
	endfunction

	// Floor of 2^frac * f(v*num/den), where f is the Lab companding function.
	// Only a zero component reaches the linear branch, where the entry is 4/29.
	function automatic logic [63:0] compand_entry(input int unsigned v, input int unsigned num,
			input int unsigned den, input int unsigned frac);
		logic [127:0] vn;
		logic [127:0] rhs;
		logic [127:0] lhs;
		logic [127:0] q;
		logic [127:0] c;
		vn = 128'(v) * 128'(num);
		q = '0;
		if (vn * 128'd1000000 > 128'd8856 * 128'(den)) begin
			rhs = vn << (3 * frac);
			for (int b = 31; b >= 0; b--) begin
				if (b <= int'(frac)) begin
					c = q | (128'd1 << b);
					lhs = c * c;
					lhs = lhs * c;
					lhs = lhs * 128'(den);
					if (lhs <= rhs) begin
						q = c;
					end
				end
			end
		end else begin
			q = (128'd4 << frac) / 128'd29;
		end
		return q[63:0];
	endfunction

endpackage

`default_nettype wire

[hdl/rgb_to_lab_pixel_converter.sv]
// Five-stage fixed-point RGB to CIE Lab pixel converter.
//
// channel  direction  handshake            fields
// in       sink       in_valid/in_stall    red, green, blue
// out      source     out_valid/out_stall  lightness, chroma_a, chroma_b
//
// One pixel per clock unless out stalls; a pixel passes through each stage in turn to out.
// Stages: products, matrix sum and clamp, companding table read, scaling, truncation and clamp.
// Reset clears only the stage valid bits, so the pipeline starts empty.
// A stall on out holds the full stages in an unbroken run back from out and lets the others move up.
// in_stall rises only when every stage holds a pixel and out is stalled.
`default_nettype none

module rgb_to_lab_pixel_converter #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] red,
	input  wire logic [7:0] green,
	input  wire logic [7:0] blue,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      lightness,
	output logic [7:0]      chroma_a,
	output logic [7:0]      chroma_b
);

	localparam int CW = FRAC_BITS;       // matrix coefficient
	localparam int PW = CW + 8;          // one product
	localparam int AW = PW + 2;          // sum of three products
	localparam int FW = FRAC_BITS + 1;   // companding table entry, below 2.0
	localparam int SW = FRAC_BITS + 11;  // signed scaled L, a, b

	typedef logic [CW-1:0] coef_arr_t [9];
	typedef logic [FW-1:0] lut_t [256];

	function automatic coef_arr_t build_coef();
		coef_arr_t res;
		logic [63:0] tmp;
		for (int k = 0; k < 9; k++) begin
			tmp = r2l_pkg::coef_fx(r2l_pkg::MAT_MICRO[k], FRAC_BITS);
			res[k] = tmp[CW-1:0];
		end
		return res;
	endfunction

	function automatic lut_t build_lut(input int unsigned num, input int unsigned den);
		lut_t res;
		logic [63:0] tmp;
		for (int i = 0; i < 256; i++) begin
			tmp = r2l_pkg::compand_entry(i, num, den, FRAC_BITS);
			res[i] = tmp[FW-1:0];
		end
		return res;
	endfunction

	// Truncate toward zero, add the offset and saturate to 0..255.
	function automatic logic [7:0] finish(input logic signed [SW-1:0] fx,
			input logic [7:0] offset);
		logic [SW-1:0] mag;
		logic signed [12:0] whole;
		mag = fx[SW-1] ? SW'(-fx) : SW'(fx);
		whole = $signed({3'b000, mag[FRAC_BITS+9:FRAC_BITS]});
		if (fx[SW-1]) begin
			whole = -whole;
		end
		whole = whole + $signed({5'b00000, offset});
		if (whole < 0) begin
			return 8'd0;
		end else if (whole > 13'sd255) begin
			return 8'd255;
		end else begin
			return whole[7:0];
		end
	endfunction

	localparam coef_arr_t COEF = build_coef();
	localparam lut_t LUT_X = build_lut(r2l_pkg::WP_NUM[0], r2l_pkg::WP_DEN[0]);
	localparam lut_t LUT_Y = build_lut(r2l_pkg::WP_NUM[1], r2l_pkg::WP_DEN[1]);
	localparam lut_t LUT_Z = build_lut(r2l_pkg::WP_NUM[2], r2l_pkg::WP_DEN[2]);

	localparam logic signed [SW-1:0] K116 = SW'(116);
	localparam logic signed [SW-1:0] K500 = SW'(500);
	localparam logic signed [SW-1:0] K200 = SW'(200);
	localparam logic signed [SW-1:0] L_BIAS = SW'(16) << FRAC_BITS;

	// Stage enables: a stage loads when it is empty or the one after it moves.
	logic en_s1, en_s2, en_s3, en_s4, en_s5;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	assign en_s5 = !v_s5 || !out_stall;
	assign en_s4 = !v_s4 || en_s5;
	assign en_s3 = !v_s3 || en_s4;
	assign en_s2 = !v_s2 || en_s3;
	assign en_s1 = !v_s1 || en_s2;
	assign in_stall = !en_s1;
	assign out_valid = v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s1) begin
				v_s1 <= in_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
			if (en_s5) begin
				v_s5 <= v_s4;
			end
		end
	end

	logic [7:0] pix [3];
	assign pix[0] = red;
	assign pix[1] = green;
	assign pix[2] = blue;

	logic [PW-1:0] prod_s1 [9];
	logic [7:0] xyz_s2 [3];
	logic [FW-1:0] fx_s3, fy_s3, fz_s3;
	logic signed [SW-1:0] l_s4, a_s4, b_s4;
	logic [7:0] lightness_s5, chroma_a_s5, chroma_b_s5;

	logic [7:0] xyz_d [3];
	logic [AW-1:0] acc_d [3];
	logic signed [SW-1:0] fx_e, fy_e, fz_e;

	// Matrix row sums, truncated to integers and saturated at 255.
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			acc_d[k] = AW'(prod_s1[3*k]) + AW'(prod_s1[3*k+1]) + AW'(prod_s1[3*k+2]);
			if (acc_d[k][AW-1:FRAC_BITS] > (AW-FRAC_BITS)'(255)) begin
				xyz_d[k] = 8'd255;
			end else begin
				xyz_d[k] = acc_d[k][FRAC_BITS+7:FRAC_BITS];
			end
		end
	end

	assign fx_e = $signed({{(SW-FW){1'b0}}, fx_s3});
	assign fy_e = $signed({{(SW-FW){1'b0}}, fy_s3});
	assign fz_e = $signed({{(SW-FW){1'b0}}, fz_s3});

	always_ff @(posedge clk) begin
		if (en_s1) begin
			for (int k = 0; k < 9; k++) begin
				prod_s1[k] <= PW'(pix[k % 3]) * PW'(COEF[k]);
			end
		end
		if (en_s2) begin
			for (int k = 0; k < 3; k++) begin
				xyz_s2[k] <= xyz_d[k];
			end
		end
		if (en_s3) begin
			fx_s3 <= LUT_X[xyz_s2[0]];
			fy_s3 <= LUT_Y[xyz_s2[1]];
			fz_s3 <= LUT_Z[xyz_s2[2]];
		end
		if (en_s4) begin
			l_s4 <= K116 * fy_e - L_BIAS;
			a_s4 <= K500 * (fx_e - fy_e);
			b_s4 <= K200 * (fy_e - fz_e);
		end
		if (en_s5) begin
			lightness_s5 <= finish(l_s4, r2l_pkg::OFFSET_L);
			chroma_a_s5  <= finish(a_s4, r2l_pkg::OFFSET_AB);
			chroma_b_s5  <= finish(b_s4, r2l_pkg::OFFSET_AB);
		end
	end

	assign lightness = lightness_s5;
	assign chroma_a  = chroma_a_s5;
	assign chroma_b  = chroma_b_s5;

endmodule

`default_nettype wire

[hdl/r2l_checker.sv]
// Port-level checker for the RGB to Lab converter and its bind to the top level.
`default_nettype none

`include "rgb_to_lab_pixel_converter_macros.svh"

module r2l_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] lightness,
	input wire logic [7:0] chroma_a,
	input wire logic [7:0] chroma_b
);

	// A stalled result stays offered and unchanged.
	`R2L_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(lightness) && $stable(chroma_a) && $stable(chroma_b), "stalled result changed or dropped")

	// The input side only backs up while a result is offered on out and stalled.
	`R2L_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled while the pipeline can move")

	// Without output stalls, a transfer in reaches the output once it has passed through every stage.
	`R2L_ASSERT_NEXT(a_latency, (in_valid && !in_stall && !out_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall, out_valid, "pixel did not arrive after five cycles")

endmodule

bind rgb_to_lab_pixel_converter r2l_checker u_r2l_checker (.*);

`default_nettype wire

[tb/rgb_to_lab_pixel_converter_test.sv]
// Scoreboard testbench for the RGB to Lab pixel converter, with its own fixed-point predictor.
module rgb_to_lab_pixel_converter_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = 16;
	localparam int unsigned MATRIX_MICRO [9] = '{
		412453, 357580, 180423,
		212671, 715160, 72169,
		19334, 119193, 950227
	};
	localparam int unsigned WHITE_NUM [3] = '{1000, 1, 1000};
	localparam int unsigned WHITE_DEN [3] = '{95047, 100, 108883};
	localparam longint OFFSET_CHROMA = 128;

	class lab_scoreboard;
		typedef struct {
			logic [7:0] l;
			logic [7:0] a;
			logic [7:0] b;
		} lab_pixel_t;

		lab_pixel_t lab_expected_q[$];
		int unsigned errors;
		logic [63:0] coef[9];
		logic [63:0] cube_root_tab[3][256];

		function new();
			errors = 0;
			for (int k = 0; k < 9; k++) begin
				coef[k] = ((64'(MATRIX_MICRO[k]) << FRAC) + 64'd500000) / 64'd1000000;
			end
			for (int k = 0; k < 3; k++) begin
				for (int v = 0; v < 256; v++) begin
					cube_root_tab[k][v] = lab_curve(v, WHITE_NUM[k], WHITE_DEN[k]);
				end
			end
		endfunction

		// Floor of 2^FRAC times the Lab companding function of v*num/den.
		function logic [63:0] lab_curve(int unsigned v, int unsigned num, int unsigned den);
			logic [127:0] vn;
			logic [127:0] rhs;
			logic [127:0] cube;
			logic [127:0] c;
			logic [127:0] q;
			int i;
			vn = 128'(v) * 128'(num);
			if (vn * 128'd1000000 > 128'd8856 * 128'(den)) begin
				rhs = vn << (3 * FRAC);
				q = '0;
				for (i = FRAC; i >= 0; i--) begin
					c = q | (128'd1 << i);
					cube = c * c * c * 128'(den);
					if (cube <= rhs) begin
						q = c;
					end
				end
				return q[63:0];
			end
			q = ((vn * 128'd7787 * 128'd29 + 128'd4000 * 128'(den)) << FRAC) /
				(128'd29000 * 128'(den));
			return q[63:0];
		endfunction

		// Truncates toward zero, adds the offset and saturates to a byte.
		function logic [7:0] trunc_saturate(longint fx, longint offset);
			longint whole;
			if (fx < 0) begin
				whole = -((-fx) >>> FRAC);
			end else begin
				whole = fx >>> FRAC;
			end
			whole += offset;
			if (whole < 0) begin
				return 8'd0;
			end
			if (whole > 255) begin
				return 8'd255;
			end
			return 8'(whole);
		endfunction

		function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
			logic [63:0] rgb[3];
			logic [63:0] acc;
			longint f[3];
			lab_pixel_t px;
			rgb[0] = 64'(r);
			rgb[1] = 64'(g);
			rgb[2] = 64'(b);
			for (int k = 0; k < 3; k++) begin
				acc = 0;
				for (int j = 0; j < 3; j++) begin
					acc += rgb[j] * coef[k * 3 + j];
				end
				acc = acc >> FRAC;
				if (acc > 255) begin
					acc = 255;
				end
				f[k] = longint'(cube_root_tab[k][acc[7:0]]);
			end
			px.l = trunc_saturate(116 * f[1] - (longint'(16) << FRAC), 0);
			px.a = trunc_saturate(500 * (f[0] - f[1]), OFFSET_CHROMA);
			px.b = trunc_saturate(200 * (f[1] - f[2]), OFFSET_CHROMA);
			lab_expected_q.insert(lab_expected_q.size(), px);
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			end
		endfunction

		function void check_result(logic [7:0] l, logic [7:0] a, logic [7:0] b);
			lab_pixel_t px;
			if (lab_expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, got L=%0d a=%0d b=%0d",
					$time, l, a, b);
				return;
			end
			px = lab_expected_q.pop_front();
			compare_field("lightness", px.l, l);
			compare_field("chroma_a", px.a, a);
			compare_field("chroma_b", px.b, b);
		endfunction

		function int pending();
			return lab_expected_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic out_valid;
	logic out_stall;
	logic [7:0] lightness;
	logic [7:0] chroma_a;
	logic [7:0] chroma_b;

	bit long_hold;
	lab_scoreboard sb;

	rgb_to_lab_pixel_converter uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.red(red),
		.green(green),
		.blue(blue),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.lightness(lightness),
		.chroma_a(chroma_a),
		.chroma_b(chroma_b)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end else if (r < 98) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 50);
	endfunction

	function automatic logic [7:0] pick_component();
		int r;
		r = $urandom_range(0, 2);
		if (r == 0) begin
			return 8'd0;
		end else if (r == 1) begin
			return 8'd255;
		end
		return 8'($urandom_range(0, 255));
	endfunction

	// Entered and left at a falling edge; valid stays up until the transfer.
	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
			input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		red <= r;
		green <= g;
		blue <= b;
		do @(posedge clk); while (in_stall);
		sb.note_pixel(r, g, b);
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(negedge clk); while (sb.pending() != 0);
	endtask

	// Receiver: runs of ready and stalled cycles, and one long hold-off on request.
	initial begin
		int mode;
		int len;
		logic s;
		out_stall = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			mode = $urandom_range(0, 99);
			if (long_hold) begin
				long_hold = 1'b0;
				s = 1'b1;
				len = 80;
			end else if (mode < 5) begin
				s = 1'b0;
				len = $urandom_range(50, 150);
			end else if (mode < 50) begin
				s = 1'b0;
				len = $urandom_range(1, 20);
			end else if (mode < 92) begin
				s = 1'b1;
				len = $urandom_range(1, 3);
			end else begin
				s = 1'b1;
				len = $urandom_range(10, 40);
			end
			out_stall <= s;
			repeat (len) @(negedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_result(lightness, chroma_a, chroma_b);
		end
	end

	initial begin
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] directed [16][3];
		int kind;
		directed = '{
			'{8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255}, '{8'd255, 8'd0, 8'd0},
			'{8'd0, 8'd255, 8'd0}, '{8'd0, 8'd0, 8'd255}, '{8'd255, 8'd255, 8'd0},
			'{8'd0, 8'd255, 8'd255}, '{8'd255, 8'd0, 8'd255}, '{8'd1, 8'd1, 8'd1},
			'{8'd128, 8'd128, 8'd128}, '{8'd0, 8'd0, 8'd1}, '{8'd1, 8'd0, 8'd0},
			'{8'd0, 8'd1, 8'd0}, '{8'd254, 8'd254, 8'd254}, '{8'd170, 8'd85, 8'd0},
			'{8'd85, 8'd170, 8'd255}
		};
		long_hold = 1'b0;
		in_valid = 1'b0;
		red = 8'd0;
		green = 8'd0;
		blue = 8'd0;
		arst_n = 1'b0;
		sb = new();
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Field extremes, primaries, saturation of a and b, and zero components.
		for (int i = 0; i < 16; i++) begin
			send_pixel(directed[i][0], directed[i][1], directed[i][2], pick_gap());
		end
		drain_results();

		for (int i = 0; i < 1200; i++) begin
			// The long hold-off fills the pipeline while the sender keeps offering.
			if (i == 100) begin
				long_hold = 1'b1;
			end
			if (i == 600) begin
				drain_results();
			end
			kind = $urandom_range(0, 99);
			if (kind < 65) begin
				r = 8'($urandom_range(0, 255));
				g = 8'($urandom_range(0, 255));
				b = 8'($urandom_range(0, 255));
			end else if (kind < 85) begin
				r = pick_component();
				g = pick_component();
				b = pick_component();
			end else begin
				r = 8'($urandom_range(0, 255));
				g = r;
				b = r;
			end
			send_pixel(r, g, b, (i >= 800 && i < 950) ? 0 : pick_gap());
		end
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (sb.errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
